### rtl/core/slir_pkg.sv
// Shared types and constants for the sorted insertion list.
package slir_pkg;

  localparam int CAPACITY = 16;
  localparam int VALUE_W  = 32;
  localparam int POS_W    = 4;
  localparam int COUNT_W  = $clog2(CAPACITY + 1);

  localparam logic [1:0] ACT_INSERT = 2'd0;
  localparam logic [1:0] ACT_REMOVE = 2'd1;
  localparam logic [1:0] ACT_READ   = 2'd2;

  localparam logic [1:0] ST_OK          = 2'd0;
  localparam logic [1:0] ST_FULL        = 2'd1;
  localparam logic [1:0] ST_NOT_FOUND   = 2'd2;
  localparam logic [1:0] ST_NO_POSITION = 2'd3;

  typedef struct packed {
    logic [1:0]                action;
    logic signed [VALUE_W-1:0] value;
    logic [POS_W-1:0]          position;
  } in_item_t;

  typedef struct packed {
    logic [1:0]                status;
    logic signed [VALUE_W-1:0] entry_value;
    logic [4:0]                entry_count;
  } out_item_t;

  // Broadcast to every cell in a cycle.
  typedef struct packed {
    logic                      insert;
    logic                      remove;
    logic signed [VALUE_W-1:0] value;
  } cell_cmd_t;

  // What a cell shows its neighbours and the control.
  typedef struct packed {
    logic signed [VALUE_W-1:0] value;
    logic                      occupied;
    logic                      shift;    // at or beyond the insert slot
    logic                      ge;       // occupied and not below the key
    logic                      hit;      // first entry equal to the key
  } cell_link_t;

endpackage

### rtl/core/sorted_list_insert_remove_unit.sv
// Top level of the sorted insertion list: cell row, entry count and result register.
//
// Keeps up to CAPACITY signed 32-bit entries in ascending order in a row of
// cells. Each input item on in_item/in_valid/in_ready holds an action:
// insert, remove the first equal entry, or read the entry at a position.
// Every item yields exactly one result on out_item/out_valid/out_ready with
// a status, the read value (zero otherwise) and the entry count after it.
// All cells compare against the broadcast key in the same cycle and shift
// by one place towards their neighbour, so an item completes in the cycle
// it is accepted and its result is registered, one item per cycle
// sustained while out_ready stays high. The result register is the only
// buffer; in_ready is high while it is empty or being taken, so a stalled
// receiver holds the result and stops further items until it is taken.
// Reset empties the table and drops any pending result; no clearing pass
// is needed, entries are tracked by per-cell occupied flags.
// The unused action code is answered with status ok and no change.
module sorted_list_insert_remove_unit (
  input  logic                clk,
  input  logic                rst,
  input  slir_pkg::in_item_t  in_item,
  input  logic                in_valid,
  output logic                in_ready,
  output slir_pkg::out_item_t out_item,
  output logic                out_valid,
  input  logic                out_ready
);
  import slir_pkg::*;

  cell_cmd_t               cmd;
  cell_link_t              links [CAPACITY];
  cell_link_t              lefts [CAPACITY];
  cell_link_t              rights [CAPACITY];
  logic [COUNT_W-1:0]      stored_count;
  logic [COUNT_W-1:0]      stored_count_next;
  logic                    accept;
  logic                    full;
  logic                    found;
  logic                    pos_valid;
  logic signed [VALUE_W-1:0] read_value;
  out_item_t               result;

  assign accept   = in_valid && in_ready;
  assign in_ready = !out_valid || out_ready;
  assign full     = (stored_count == COUNT_W'(CAPACITY));

  always_comb begin
    found      = 1'b0;
    read_value = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      found = found | links[i].hit;
      if (COUNT_W'(i) == COUNT_W'(in_item.position)) begin
        read_value = links[i].value;
      end
    end
  end

  assign pos_valid = (COUNT_W'(in_item.position) < stored_count);

  always_comb begin
    cmd.value  = in_item.value;
    cmd.insert = accept && (in_item.action == ACT_INSERT) && !full;
    cmd.remove = accept && (in_item.action == ACT_REMOVE) && found;
  end

  // Wire the row: cell 0 sees an occupied, never-shifting left edge.
  always_comb begin
    for (int i = 0; i < CAPACITY; i++) begin
      if (i == 0) begin
        lefts[i] = '{value: '0, occupied: 1'b1, shift: 1'b0, ge: 1'b0, hit: 1'b0};
      end else begin
        lefts[i] = links[i-1];
      end
      if (i == CAPACITY - 1) begin
        rights[i] = '{value: '0, occupied: 1'b0, shift: 1'b0, ge: 1'b0, hit: 1'b0};
      end else begin
        rights[i] = links[i+1];
      end
    end
  end

  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    slir_cell u_cell (
      .clk   (clk),
      .rst   (rst),
      .cmd   (cmd),
      .left  (lefts[g]),
      .right (rights[g]),
      .link  (links[g])
    );
  end

  always_comb begin
    stored_count_next = stored_count;
    if (cmd.insert) begin
      stored_count_next = stored_count + COUNT_W'(1);
    end else if (cmd.remove) begin
      stored_count_next = stored_count - COUNT_W'(1);
    end
  end

  always_comb begin
    result.status      = ST_OK;
    result.entry_value = '0;
    result.entry_count = 5'(stored_count_next);
    case (in_item.action)
      ACT_INSERT: begin
        if (full) result.status = ST_FULL;
      end
      ACT_REMOVE: begin
        if (!found) result.status = ST_NOT_FOUND;
      end
      ACT_READ: begin
        if (pos_valid) begin
          result.entry_value = read_value;
        end else begin
          result.status = ST_NO_POSITION;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stored_count <= '0;
      out_valid    <= 1'b0;
    end else begin
      stored_count <= stored_count_next;
      if (accept) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_item <= result;
    end
  end

endmodule

### rtl/core/slir_cell.sv
// One entry of the sorted table with its compare and shift logic.
module slir_cell (
  input  logic                clk,
  input  logic                rst,
  input  slir_pkg::cell_cmd_t  cmd,
  input  slir_pkg::cell_link_t left,
  input  slir_pkg::cell_link_t right,
  output slir_pkg::cell_link_t link
);
  import slir_pkg::*;

  logic signed [VALUE_W-1:0] value;
  logic                      occupied;
  logic                      gt;

  always_comb begin
    gt            = occupied && (value > cmd.value);
    link.value    = value;
    link.occupied = occupied;
    link.ge       = occupied && (value >= cmd.value);
    link.shift    = !occupied || gt;
    link.hit      = occupied && (value == cmd.value) && !left.ge;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      occupied <= 1'b0;
    end else if (cmd.insert) begin
      occupied <= occupied | left.occupied;
    end else if (cmd.remove && link.ge) begin
      occupied <= right.occupied;
    end
  end

  // Insert: cells past the slot take the left value, the slot takes the key.
  // Remove: cells from the hit onwards take the right value.
  always_ff @(posedge clk) begin
    if (cmd.insert && link.shift) begin
      value <= left.shift ? left.value : cmd.value;
    end else if (cmd.remove && link.ge) begin
      value <= right.value;
    end
  end

endmodule
